/* hw/rtl/ruci_pkg.sv */
// types shared by the unit cylinder intersection pipeline
package ruci_pkg;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } ray_in_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] t_first;
    logic signed [31:0] t_second;
  } ray_out_t;

  typedef struct packed {
    ray_in_t            ray;
    logic        [63:0] a;
    logic signed [64:0] bw;
    logic               tube_ok;
  } sq_side_t;

  typedef struct packed {
    ray_in_t ray;
    logic    tube_ok;
  } div_side_t;

  typedef struct packed {
    logic [81:0] mag;
    logic [63:0] den;
    logic        neg;
  } div_lane_t;

  localparam logic [31:0] SAT_HI = 32'h7fff_ffff;
  localparam logic [31:0] SAT_LO = 32'h8000_0000;

endpackage

/* hw/rtl/ruci_isqrt.sv */
// pipelined integer square root, one root bit per stage
module ruci_isqrt (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [127:0]       in_d,
  input  ruci_pkg::sq_side_t in_side,
  output logic               out_valid,
  output logic [63:0]        out_root,
  output ruci_pkg::sq_side_t out_side
);

  logic [63:0]        v;
  logic [127:0]       rem [64];
  logic [63:0]        root [64];
  ruci_pkg::sq_side_t side [64];
  logic [127:0]       src_rem [64];
  logic [63:0]        src_root [64];
  logic [127:0]       trial [64];
  logic [127:0]       rem_next [64];
  logic [63:0]        root_next [64];

  always_comb begin
    src_rem[0]  = in_d;
    src_root[0] = '0;
    for (int k = 1; k < 64; k++) begin
      src_rem[k]  = rem[k-1];
      src_root[k] = root[k-1];
    end
    for (int k = 0; k < 64; k++) begin
      trial[k] = ({64'd0, src_root[k]} << (64 - k)) | (128'd1 << (126 - 2 * k));
      if (src_rem[k] >= trial[k]) begin
        rem_next[k]  = src_rem[k] - trial[k];
        root_next[k] = src_root[k] | (64'd1 << (63 - k));
      end else begin
        rem_next[k]  = src_rem[k];
        root_next[k] = src_root[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[62:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= in_side;
      for (int k = 1; k < 64; k++) side[k] <= side[k-1];
      for (int k = 0; k < 64; k++) begin
        rem[k]  <= rem_next[k];
        root[k] <= root_next[k];
      end
    end
  end

  assign out_valid = v[63];
  assign out_root  = root[63];
  assign out_side  = side[63];

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    v[63] |-> rem[63] <= {63'd0, root[63], 1'b0})
    else $error("square root remainder above twice the root");

endmodule

/* hw/rtl/ruci_div.sv */
// four lane pipelined restoring divider with saturation to q16.16
module ruci_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  ruci_pkg::div_lane_t [3:0] in_lane,
  input  ruci_pkg::div_side_t       in_side,
  output logic                      out_valid,
  output logic [3:0][31:0]          out_q,
  output ruci_pkg::div_side_t       out_side
);

  typedef struct packed {
    logic [81:0] rem;
    logic [63:0] den;
    logic        neg;
    logic        ovf;
    logic [31:0] q;
  } dstage_t;

  logic [32:0]         v;
  dstage_t             st [33][4];
  dstage_t             nxt [33][4];
  logic [95:0]         sh [33][4];
  ruci_pkg::div_side_t side [33];
  logic [3:0][31:0]    sat;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      sh[0][l]      = {in_lane[l].den, 32'd0};
      nxt[0][l].rem = in_lane[l].mag;
      nxt[0][l].den = in_lane[l].den;
      nxt[0][l].neg = in_lane[l].neg;
      nxt[0][l].ovf = {14'd0, in_lane[l].mag} >= sh[0][l];
      nxt[0][l].q   = '0;
    end
    for (int j = 1; j < 33; j++) begin
      for (int l = 0; l < 4; l++) begin
        nxt[j][l] = st[j-1][l];
        sh[j][l]  = {32'd0, st[j-1][l].den} << (32 - j);
        if (!st[j-1][l].ovf && ({14'd0, st[j-1][l].rem} >= sh[j][l])) begin
          nxt[j][l].rem = st[j-1][l].rem - sh[j][l][81:0];
          nxt[j][l].q   = st[j-1][l].q | (32'd1 << (32 - j));
        end
      end
    end
    for (int l = 0; l < 4; l++) begin
      if (st[32][l].ovf) begin
        sat[l] = st[32][l].neg ? ruci_pkg::SAT_LO : ruci_pkg::SAT_HI;
      end else if (!st[32][l].neg) begin
        sat[l] = st[32][l].q[31] ? ruci_pkg::SAT_HI : st[32][l].q;
      end else begin
        sat[l] = (st[32][l].q > ruci_pkg::SAT_LO) ? ruci_pkg::SAT_LO
                                                   : (~st[32][l].q + 32'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      v         <= {v[31:0], in_valid};
      out_valid <= v[32];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= in_side;
      for (int j = 1; j < 33; j++) side[j] <= side[j-1];
      for (int j = 0; j < 33; j++) begin
        for (int l = 0; l < 4; l++) st[j][l] <= nxt[j][l];
      end
      out_q    <= sat;
      out_side <= side[32];
    end
  end

  a_ovf_sat: assert property (@(posedge clk) disable iff (rst)
    en && v[32] && st[32][0].ovf && !st[32][0].neg |=> out_q[0] == ruci_pkg::SAT_HI)
    else $error("overflowed quotient not saturated");

endmodule

/* hw/rtl/ray_unit_cylinder_intersect.sv */
// ray against closed unit cylinder, fully pipelined
//
//  channel | signals                          | payload
//  --------+----------------------------------+----------------------------
//  in      | in_valid, in_stall               | ruci_pkg::ray_in_t
//  out     | out_valid, out_stall             | ruci_pkg::ray_out_t
//  cfg     | cfg_wr_en, cfg_wr_data           | epsilon, 16 bit
//
// one ray per cycle while the output is not stalled; most of the pipeline depth is the
// 64 stage square root and the divider
// synchronous reset clears all valid bits and sets epsilon to 1
// a stalled output result freezes the whole pipeline, nothing lost or repeated
module ray_unit_cylinder_intersect (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  ruci_pkg::ray_in_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ruci_pkg::ray_out_t out_data
);

  localparam logic [63:0]        ONE_Q32 = 64'h1_0000_0000;
  localparam logic signed [63:0] Y_LIM   = 64'sd2147483648;

  logic        en;
  logic [15:0] eps;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= 16'd1;
    end else if (cfg_wr_en) begin
      eps <= cfg_wr_data;
    end
  end

  // valid bits of the top level stages
  logic v1, v2, v3, v4, v5, v7, v8, v9, v10, v11, v12;

  // stage 1: products
  ruci_pkg::ray_in_t  r1;
  logic signed [63:0] p_dxdx, p_dzdz, p_oxdx, p_ozdz, p_oxox, p_ozoz;

  always_ff @(posedge clk) begin
    if (en) begin
      r1     <= in_data;
      p_dxdx <= in_data.dir_x * in_data.dir_x;
      p_dzdz <= in_data.dir_z * in_data.dir_z;
      p_oxdx <= in_data.origin_x * in_data.dir_x;
      p_ozdz <= in_data.origin_z * in_data.dir_z;
      p_oxox <= in_data.origin_x * in_data.origin_x;
      p_ozoz <= in_data.origin_z * in_data.origin_z;
    end
  end

  // stage 2: quadratic coefficients
  logic [63:0]        a_c, ss_c, bm_c, cm_c;
  logic signed [64:0] bw_c, nbw_c;
  logic               cneg_c, aok_c;

  always_comb begin
    a_c    = $unsigned(p_dxdx) + $unsigned(p_dzdz);
    bw_c   = $signed({p_oxdx[63], p_oxdx}) + $signed({p_ozdz[63], p_ozdz});
    nbw_c  = -bw_c;
    bm_c   = bw_c[64] ? nbw_c[63:0] : bw_c[63:0];
    ss_c   = $unsigned(p_oxox) + $unsigned(p_ozoz);
    cneg_c = ss_c < ONE_Q32;
    cm_c   = cneg_c ? (ONE_Q32 - ss_c) : (ss_c - ONE_Q32);
    aok_c  = (a_c != 64'd0) && (a_c >= {32'd0, eps, 16'd0});
  end

  ruci_pkg::ray_in_t  r2;
  logic [63:0]        a2, bm2, cm2;
  logic signed [64:0] bw2;
  logic               cneg2, aok2;

  always_ff @(posedge clk) begin
    if (en) begin
      r2    <= r1;
      a2    <= a_c;
      bw2   <= bw_c;
      bm2   <= bm_c;
      cm2   <= cm_c;
      cneg2 <= cneg_c;
      aok2  <= aok_c;
    end
  end

  // stage 3: partial products of b squared and a times c
  ruci_pkg::ray_in_t  r3;
  logic [63:0]        a3;
  logic signed [64:0] bw3;
  logic               cneg3, aok3;
  logic [63:0]        pb00, pb01, pb11, pa00, pa01, pa10, pa11;

  always_ff @(posedge clk) begin
    if (en) begin
      r3    <= r2;
      a3    <= a2;
      bw3   <= bw2;
      cneg3 <= cneg2;
      aok3  <= aok2;
      pb00  <= bm2[31:0] * bm2[31:0];
      pb01  <= bm2[31:0] * bm2[63:32];
      pb11  <= bm2[63:32] * bm2[63:32];
      pa00  <= a2[31:0] * cm2[31:0];
      pa01  <= a2[31:0] * cm2[63:32];
      pa10  <= a2[63:32] * cm2[31:0];
      pa11  <= a2[63:32] * cm2[63:32];
    end
  end

  // stage 4: sum of partial products
  ruci_pkg::ray_in_t  r4;
  logic [63:0]        a4;
  logic signed [64:0] bw4;
  logic               cneg4, aok4;
  logic [127:0]       bb4, ac4;

  always_ff @(posedge clk) begin
    if (en) begin
      r4    <= r3;
      a4    <= a3;
      bw4   <= bw3;
      cneg4 <= cneg3;
      aok4  <= aok3;
      bb4   <= {pb11, 64'd0} + {31'd0, pb01, 33'd0} + {64'd0, pb00};
      ac4   <= {pa11, 64'd0} + {32'd0, pa01, 32'd0} + {32'd0, pa10, 32'd0}
               + {64'd0, pa00};
    end
  end

  // stage 5: discriminant
  logic [127:0]       d5;
  ruci_pkg::sq_side_t side5;

  always_ff @(posedge clk) begin
    if (en) begin
      d5            <= cneg4 ? (bb4 + ac4) : (bb4 - ac4);
      side5.ray     <= r4;
      side5.a       <= a4;
      side5.bw      <= bw4;
      side5.tube_ok <= aok4 && (cneg4 || (bb4 >= ac4));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  logic               sq_valid;
  logic [63:0]        sq_root;
  ruci_pkg::sq_side_t sq_side;

  ruci_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v5),
    .in_d      (d5),
    .in_side   (side5),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // stage 6: divider operands
  logic signed [66:0]        nb_c, n0_c, n1_c, an0_c, an1_c;
  logic signed [33:0]        oy_e, nc0_c, nc1_c, anc0_c, anc1_c;
  logic [31:0]               ady_c;
  ruci_pkg::div_lane_t [3:0] lane_c, lane6;
  ruci_pkg::div_side_t       side6;
  logic                      v6;

  always_comb begin
    nb_c   = -$signed({{2{sq_side.bw[64]}}, sq_side.bw});
    n0_c   = nb_c - $signed({3'd0, sq_root});
    n1_c   = nb_c + $signed({3'd0, sq_root});
    an0_c  = n0_c[66] ? -n0_c : n0_c;
    an1_c  = n1_c[66] ? -n1_c : n1_c;
    oy_e   = $signed({{2{sq_side.ray.origin_y[31]}}, sq_side.ray.origin_y});
    nc0_c  = -34'sd32768 - oy_e;
    nc1_c  = 34'sd32768 - oy_e;
    anc0_c = nc0_c[33] ? -nc0_c : nc0_c;
    anc1_c = nc1_c[33] ? -nc1_c : nc1_c;
    ady_c  = sq_side.ray.dir_y[31] ? (~sq_side.ray.dir_y + 32'd1) : sq_side.ray.dir_y;
    lane_c[0].mag = {1'b0, an0_c[64:0], 16'd0};
    lane_c[0].den = sq_side.a;
    lane_c[0].neg = n0_c[66];
    lane_c[1].mag = {1'b0, an1_c[64:0], 16'd0};
    lane_c[1].den = sq_side.a;
    lane_c[1].neg = n1_c[66];
    lane_c[2].mag = {33'd0, anc0_c[32:0], 16'd0};
    lane_c[2].den = {32'd0, ady_c};
    lane_c[2].neg = nc0_c[33] ^ sq_side.ray.dir_y[31];
    lane_c[3].mag = {33'd0, anc1_c[32:0], 16'd0};
    lane_c[3].den = {32'd0, ady_c};
    lane_c[3].neg = nc1_c[33] ^ sq_side.ray.dir_y[31];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane6         <= lane_c;
      side6.ray     <= sq_side.ray;
      side6.tube_ok <= sq_side.tube_ok;
    end
  end

  logic                dv_valid;
  logic [3:0][31:0]    dv_q;
  ruci_pkg::div_side_t dv_side;

  ruci_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v6),
    .in_lane   (lane6),
    .in_side   (side6),
    .out_valid (dv_valid),
    .out_q     (dv_q),
    .out_side  (dv_side)
  );

  // stage 7: height products
  ruci_pkg::ray_in_t  r7;
  logic               tok7;
  logic signed [31:0] q7 [4];
  logic signed [63:0] py0, py1;

  always_ff @(posedge clk) begin
    if (en) begin
      r7   <= dv_side.ray;
      tok7 <= dv_side.tube_ok;
      for (int l = 0; l < 4; l++) q7[l] <= $signed(dv_q[l]);
      py0  <= $signed(dv_q[0]) * dv_side.ray.dir_y;
      py1  <= $signed(dv_q[1]) * dv_side.ray.dir_y;
    end
  end

  // stage 8: height test on tube roots
  logic signed [63:0] oys_c, y0_c, y1_c;
  logic               in0_c, in1_c;

  always_comb begin
    oys_c = $signed({{16{r7.origin_y[31]}}, r7.origin_y, 16'd0});
    y0_c  = oys_c + py0;
    y1_c  = oys_c + py1;
    in0_c = (y0_c > -Y_LIM) && (y0_c < Y_LIM);
    in1_c = (y1_c > -Y_LIM) && (y1_c < Y_LIM);
  end

  ruci_pkg::ray_in_t  r8;
  logic               tv8;
  logic signed [31:0] t0_8, t1_8, c0_8, c1_8;

  always_ff @(posedge clk) begin
    if (en) begin
      r8   <= r7;
      tv8  <= tok7 && (in0_c || in1_c);
      t0_8 <= in0_c ? q7[0] : q7[1];
      t1_8 <= in1_c ? q7[1] : q7[0];
      c0_8 <= q7[2];
      c1_8 <= q7[3];
    end
  end

  // stage 9: merge with cap hits
  logic signed [32:0] dt_c, adt_c;
  logic [31:0]        ady8_c;
  logic               eqt_c, capdo_c, mv_c, mf0_c, mf1_c;
  logic signed [31:0] mt0_c, mt1_c;

  always_comb begin
    dt_c    = $signed({t0_8[31], t0_8}) - $signed({t1_8[31], t1_8});
    adt_c   = dt_c[32] ? -dt_c : dt_c;
    eqt_c   = $unsigned(adt_c) < {17'd0, eps};
    ady8_c  = r8.dir_y[31] ? (~r8.dir_y + 32'd1) : r8.dir_y;
    capdo_c = !((r8.dir_y == 32'sd0) || (ady8_c < {16'd0, eps})) && !(tv8 && !eqt_c);
    mv_c    = tv8;
    mt0_c   = t0_8;
    mt1_c   = t1_8;
    mf0_c   = tv8;
    mf1_c   = tv8;
    if (capdo_c) begin
      mt0_c = c0_8;
      mt1_c = c1_8;
      mf0_c = 1'b0;
      mf1_c = 1'b0;
      if (tv8) begin
        if (t0_8 < mt0_c) begin
          mt0_c = t0_8;
          mf0_c = 1'b1;
        end
        if (t1_8 < mt1_c) begin
          mt1_c = t1_8;
          mf1_c = 1'b1;
        end
        if (t1_8 < mt0_c) begin
          mt0_c = t1_8;
          mf0_c = 1'b1;
        end
        if (t0_8 < mt1_c) begin
          mt1_c = t0_8;
          mf1_c = 1'b1;
        end
      end
      mv_c = 1'b1;
    end
  end

  ruci_pkg::ray_in_t  r9;
  logic               mv9, f0_9, f1_9;
  logic signed [31:0] t0_9, t1_9;

  always_ff @(posedge clk) begin
    if (en) begin
      r9   <= r8;
      mv9  <= mv_c;
      f0_9 <= mf0_c;
      f1_9 <= mf1_c;
      t0_9 <= mt0_c;
      t1_9 <= mt1_c;
    end
  end

  // stage 10: radius products, order t0 x, t0 z, t1 x, t1 z
  ruci_pkg::ray_in_t  r10;
  logic               mv10, f0_10, f1_10;
  logic signed [31:0] t0_10, t1_10;
  logic signed [63:0] px [4];

  always_ff @(posedge clk) begin
    if (en) begin
      r10   <= r9;
      mv10  <= mv9;
      f0_10 <= f0_9;
      f1_10 <= f1_9;
      t0_10 <= t0_9;
      t1_10 <= t1_9;
      px[0] <= t0_9 * r9.dir_x;
      px[1] <= t0_9 * r9.dir_z;
      px[2] <= t1_9 * r9.dir_x;
      px[3] <= t1_9 * r9.dir_z;
    end
  end

  // stage 11: hit point coordinates
  logic signed [63:0] ofs_c [4];
  logic signed [63:0] xv_c [4];
  logic [63:0]        ax_c [4];

  always_comb begin
    ofs_c[0] = $signed({{16{r10.origin_x[31]}}, r10.origin_x, 16'd0});
    ofs_c[1] = $signed({{16{r10.origin_z[31]}}, r10.origin_z, 16'd0});
    ofs_c[2] = ofs_c[0];
    ofs_c[3] = ofs_c[1];
    for (int i = 0; i < 4; i++) begin
      xv_c[i] = ofs_c[i] + px[i];
      ax_c[i] = xv_c[i][63] ? $unsigned(-xv_c[i]) : $unsigned(xv_c[i]);
    end
  end

  logic               mv11, f0_11, f1_11;
  logic signed [31:0] t0_11, t1_11;
  logic [32:0]        lo11 [4];
  logic [3:0]         big11;

  always_ff @(posedge clk) begin
    if (en) begin
      mv11  <= mv10;
      f0_11 <= f0_10;
      f1_11 <= f1_10;
      t0_11 <= t0_10;
      t1_11 <= t1_10;
      for (int i = 0; i < 4; i++) begin
        lo11[i]  <= ax_c[i][32:0];
        big11[i] <= |ax_c[i][63:33];
      end
    end
  end

  // stage 12: squares
  logic               mv12, f0_12, f1_12;
  logic signed [31:0] t0_12, t1_12;
  logic [65:0]        sq12 [4];
  logic [3:0]         big12;

  always_ff @(posedge clk) begin
    if (en) begin
      mv12  <= mv11;
      f0_12 <= f0_11;
      f1_12 <= f1_11;
      t0_12 <= t0_11;
      t1_12 <= t1_11;
      big12 <= big11;
      for (int i = 0; i < 4; i++) sq12[i] <= lo11[i] * lo11[i];
    end
  end

  // stage 13: radius test and result
  logic [66:0]        rad0_c, rad1_c, thr_c;
  logic               k0_c, k1_c;
  ruci_pkg::ray_out_t res_c;

  always_comb begin
    rad0_c = {1'b0, sq12[0]} + {1'b0, sq12[1]};
    rad1_c = {1'b0, sq12[2]} + {1'b0, sq12[3]};
    thr_c  = {2'd0, 1'b1, eps, 48'd0};
    k0_c   = f0_12 || (!big12[0] && !big12[1] && (rad0_c < thr_c));
    k1_c   = f1_12 || (!big12[2] && !big12[3] && (rad1_c < thr_c));
    if (!mv12 || (!k0_c && !k1_c)) begin
      res_c.hit      = 1'b0;
      res_c.t_first  = '0;
      res_c.t_second = '0;
    end else begin
      res_c.hit      = 1'b1;
      res_c.t_first  = k0_c ? t0_12 : t1_12;
      res_c.t_second = k1_c ? t1_12 : t0_12;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v7        <= 1'b0;
      v8        <= 1'b0;
      v9        <= 1'b0;
      v10       <= 1'b0;
      v11       <= 1'b0;
      v12       <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v7        <= dv_valid;
      v8        <= v7;
      v9        <= v8;
      v10       <= v9;
      v11       <= v10;
      v12       <= v11;
      out_valid <= v12;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= res_c;
    end
  end

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.hit |-> out_data.t_first == 32'sd0 && out_data.t_second == 32'sd0)
    else $error("miss transfer carries nonzero parameters");

  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

/* sim/tb_top.sv */
// testbench for the unit cylinder intersection pipeline
module tb_top;

  localparam int LATENCY = 111;
  localparam int LIMIT   = 2000000;
  localparam int N_RAND  = 1530;

  typedef struct {
    logic [31:0] ox, oy, oz, dx, dy, dz;
    logic        chk;
    logic        hit;
    logic [31:0] t0, t1;
  } row_t;

  logic clk, rst;
  logic cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic in_valid, in_stall, out_valid, out_stall;
  ruci_pkg::ray_in_t in_data;
  ruci_pkg::ray_out_t out_data;

  ray_unit_cylinder_intersect i_dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  ruci_pkg::ray_out_t hits_due[$];
  logic [15:0] eps_q;
  int errors;
  int cycles;
  bit hold_long;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [127:0] isqrt(logic [127:0] d);
    logic [127:0] res, bitv, rb;
    res = 0;
    bitv = 128'd1 << 126;
    while (bitv != 0 && d < bitv) bitv = bitv >> 2;
    while (bitv != 0) begin
      rb = res + bitv;
      if (d >= rb) begin
        d = d - rb;
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [63:0] sat(logic signed [127:0] v);
    if (v > 128'sd2147483647) return 64'sd2147483647;
    if (v < -128'sd2147483648) return -64'sd2147483648;
    return v[63:0];
  endfunction

  // Q32.32 over Q32.32 to Q16.16, toward zero, saturated
  function automatic logic signed [63:0] q_div(logic signed [127:0] num, logic [63:0] den);
    logic neg;
    logic [127:0] mag, q;
    neg = num < 0;
    mag = neg ? -num : num;
    mag = mag << 16;
    if (mag >= ({64'd0, den} << 32)) return neg ? -64'sd2147483648 : 64'sd2147483647;
    q = mag / den;
    return sat(neg ? -$signed(q) : $signed(q));
  endfunction

  function automatic bit in_height(logic signed [63:0] oy, dy, t);
    logic signed [127:0] y;
    y = oy * 65536 + t * dy;
    return y > -128'sd2147483648 && y < 128'sd2147483648;
  endfunction

  function automatic bit in_radius(logic signed [63:0] ox, oz, dx, dz, t);
    logic signed [127:0] x, z;
    logic [127:0] r;
    x = ox * 65536 + t * dx;
    z = oz * 65536 + t * dz;
    r = x * x + z * z;
    return r < ((128'd1 << 64) + ({112'd0, eps_q} << 48));
  endfunction

  function automatic ruci_pkg::ray_out_t cyl_hit(ruci_pkg::ray_in_t r);
    logic signed [63:0] ox, oy, oz, dx, dy, dz, c0, c1, r0, r1, n0, n1;
    logic signed [63:0] t [2];
    logic signed [127:0] bw, cc, d;
    logic [63:0] a;
    logic [127:0] s, dmag;
    bit valid, f0, f1, k0, k1, i0, i1;
    bit tube [2];
    ruci_pkg::ray_out_t o;
    ox = r.origin_x; oy = r.origin_y; oz = r.origin_z;
    dx = r.dir_x; dy = r.dir_y; dz = r.dir_z;
    valid = 0; t[0] = 0; t[1] = 0; tube[0] = 0; tube[1] = 0;
    a = dx * dx + dz * dz;
    if (a != 0 && a >= ({48'd0, eps_q} << 16)) begin
      bw = ox * dx + oz * dz;
      cc = $signed({64'd0, ox * ox + oz * oz}) - 128'sd4294967296;
      d = bw * bw - $signed({64'd0, a}) * cc;
      if (d >= 0) begin
        s = isqrt(d);
        r0 = q_div(-bw - $signed(s), a);
        r1 = q_div(-bw + $signed(s), a);
        i0 = in_height(oy, dy, r0);
        i1 = in_height(oy, dy, r1);
        if (i0 || i1) begin
          valid = 1;
          t[0] = i0 ? r0 : r1;
          t[1] = i1 ? r1 : r0;
          tube[0] = 1; tube[1] = 1;
        end
      end
    end
    dmag = dy < 0 ? -dy : dy;
    if (!(dy == 0 || dmag < eps_q) &&
        !(valid && !(((t[0] - t[1]) < 0 ? t[1] - t[0] : t[0] - t[1]) < eps_q))) begin
      c0 = sat(((-64'sd32768 - oy) * 65536) / dy);
      c1 = sat(((64'sd32768 - oy) * 65536) / dy);
      f0 = 0; f1 = 0;
      if (valid) begin
        if (t[0] < c0) begin c0 = t[0]; f0 = 1; end
        if (t[1] < c1) begin c1 = t[1]; f1 = 1; end
        if (t[1] < c0) begin c0 = t[1]; f0 = 1; end
        if (t[0] < c1) begin c1 = t[0]; f1 = 1; end
      end
      t[0] = c0; t[1] = c1; tube[0] = f0; tube[1] = f1;
      valid = 1;
    end
    if (valid) begin
      k0 = tube[0] || in_radius(ox, oz, dx, dz, t[0]);
      k1 = tube[1] || in_radius(ox, oz, dx, dz, t[1]);
      if (!k0 && !k1) valid = 0;
      else begin
        n0 = k0 ? t[0] : t[1];
        n1 = k1 ? t[1] : t[0];
        t[0] = n0; t[1] = n1;
      end
    end
    if (!valid) begin t[0] = 0; t[1] = 0; end
    o.hit = valid;
    o.t_first = t[0][31:0];
    o.t_second = t[1][31:0];
    return o;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 8)) - 4);
      default: return 32'($signed($urandom_range(0, 262144)) - 131072);
    endcase
  endfunction

  task automatic send(ruci_pkg::ray_in_t r, bit chk, ruci_pkg::ray_out_t want);
    ruci_pkg::ray_out_t p;
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    p = cyl_hit(r);
    if (chk && p !== want) begin
      $display("%0t table row disagrees: table %h predictor %h", $time, want, p);
      errors++;
    end
    hits_due.push_back(p);
    in_valid <= 1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic set_eps(logic [15:0] v);
    in_valid <= 0;
    while (hits_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    eps_q = v;
    @(posedge clk);
    cfg_wr_en <= 0;
  endtask

  // result checking
  always @(posedge clk) begin
    ruci_pkg::ray_out_t w;
    if (!rst && out_valid && !out_stall) begin
      if (hits_due.size() == 0) begin
        $display("%0t unexpected result: actual %h", $time, out_data);
        errors++;
      end else begin
        w = hits_due.pop_front();
        if (out_data.hit !== w.hit) begin
          $display("%0t hit: expected %h actual %h", $time, w.hit, out_data.hit);
          errors++;
        end
        if (out_data.t_first !== w.t_first) begin
          $display("%0t t_first: expected %h actual %h", $time, w.t_first, out_data.t_first);
          errors++;
        end
        if (out_data.t_second !== w.t_second) begin
          $display("%0t t_second: expected %h actual %h", $time, w.t_second,
                   out_data.t_second);
          errors++;
        end
      end
    end
  end

  // receiver stall
  initial begin
    int n;
    out_stall = 0;
    @(negedge rst);
    forever begin
      if (hold_long) begin
        out_stall <= 1;
        for (n = 0; n < 400; n++) @(posedge clk);
        out_stall <= 0;
        hold_long = 0;
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall <= 1;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
        repeat (n) @(posedge clk);
        out_stall <= 0;
        @(posedge clk);
      end else begin
        out_stall <= 0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  initial begin
    row_t rows [$];
    row_t rw;
    ruci_pkg::ray_in_t r;
    ruci_pkg::ray_out_t w;
    logic [15:0] eps_set [5];
    int k, ph;
    errors = 0; cycles = 0; hold_long = 0;
    rst = 1; cfg_wr_en = 0; cfg_wr_data = 0; in_valid = 0; in_data = '0;
    eps_q = 1;
    repeat (7) @(posedge clk);
    rst <= 0;
    // zero ray: parallel and degenerate, no hit
    rows.push_back('{0, 0, 0, 0, 0, 0, 1, 0, 0, 0});
    // straight down the axis: caps at t=-0.5 and 0.5
    rows.push_back('{0, 0, 0, 0, 32'h10000, 0, 1, 1, 32'hffff8000, 32'h8000});
    // along x through the centre: tube roots -1 and 1
    rows.push_back('{0, 0, 0, 32'h10000, 0, 0, 1, 1, 32'hffff0000, 32'h10000});
    // parallel, outside height: miss
    rows.push_back('{0, 32'h10000, 0, 32'h10000, 0, 0, 1, 0, 0, 0});
    // parallel to axis, outside radius: miss
    rows.push_back('{32'h20000, 0, 0, 0, 32'h10000, 0, 1, 0, 0, 0});
    rows.push_back('{32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                     32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0, 0});
    rows.push_back('{32'h80000000, 32'h80000000, 32'h80000000,
                     32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 0});
    rows.push_back('{32'h80000000, 0, 0, 32'h7fffffff, 0, 0, 0, 0, 0, 0});
    rows.push_back('{0, 0, 0, 1, 1, 1, 0, 0, 0, 0});
    rows.push_back('{32'h10000, 0, 0, 0, 0, 32'h10000, 0, 0, 0, 0});
    rows.push_back('{0, 32'h8000, 0, 32'h8000, 32'h8000, 0, 0, 0, 0, 0});
    rows.push_back('{32'h5000, 32'hffff0000, 32'h3000, 32'h100, 32'h10000, 32'h200,
                     0, 0, 0, 0});
    rows.push_back('{32'h30000, 32'h4000, 0, 32'hfffe0000, 32'h100, 0, 0, 0, 0, 0});
    rows.push_back('{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                     32'hffffffff, 32'hffffffff, 0, 0, 0, 0});
    foreach (rows[i]) begin
      rw = rows[i];
      r = '{rw.ox, rw.oy, rw.oz, rw.dx, rw.dy, rw.dz};
      w = '{rw.hit, rw.t0, rw.t1};
      send(r, rw.chk, w);
    end
    eps_set = '{16'h0000, 16'hffff, 16'h0001, 16'h0100, 16'h0010};
    for (ph = 0; ph < 5; ph++) begin
      set_eps(eps_set[ph]);
      for (k = 0; k < N_RAND / 5; k++) begin
        if (ph == 2 && k == 50) hold_long = 1;
        if ($urandom_range(0, 3) != 0) begin
          // rays aimed near the cylinder
          r.origin_x = 32'($signed($urandom_range(0, 393216)) - 196608);
          r.origin_y = 32'($signed($urandom_range(0, 196608)) - 98304);
          r.origin_z = 32'($signed($urandom_range(0, 393216)) - 196608);
          r.dir_x = 32'($signed($urandom_range(0, 262144)) - 131072);
          r.dir_y = ($urandom_range(0, 7) == 0) ? 32'd0 :
                    32'($signed($urandom_range(0, 262144)) - 131072);
          r.dir_z = 32'($signed($urandom_range(0, 262144)) - 131072);
        end else begin
          r.origin_x = rand_coord(); r.origin_y = rand_coord(); r.origin_z = rand_coord();
          r.dir_x = rand_coord(); r.dir_y = rand_coord(); r.dir_z = rand_coord();
        end
        send(r, 0, '0);
      end
    end
    in_valid <= 0;
    while (hits_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0 && hits_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
